FILE: hdl/lvi_pkg.sv
package lvi_pkg;

    // log2 fraction precision and the normalized mantissa (Q1.30)
    localparam int LOG_FRAC = 30;
    localparam int MANT_W   = LOG_FRAC + 1;
    // exponent / shift count, wide enough for 53-bit uniforms
    localparam int K_W      = 6;
    // |ln| magnitude in Q.30 stays below 2^36
    localparam int M_W      = 36;

    localparam logic [LOG_FRAC-1:0] LN2_Q30 = 30'd744261118;

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 2;

    localparam logic [30:0] SCALE_RESET = 31'd65536;

    typedef enum logic [1:0] {
        CFG_USE_LS   = 2'd0,
        CFG_LOCATION = 2'd1,
        CFG_SCALE    = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic               use_ls;
        logic signed [31:0] location;
        logic [30:0]        scale;
    } t_cfg;

    // normalized sample handed from front to back
    typedef struct packed {
        logic              upper;
        logic [K_W-1:0]    k;
        logic [MANT_W-1:0] mant;
    } t_norm;

    typedef struct packed {
        logic f1_valid;
        logic f2_valid;
    } t_front_stat;

    typedef struct packed {
        logic signed [31:0] variate;
        logic               saturated;
    } t_result;

endpackage

FILE: hdl/lvi_fifo.sv
module lvi_fifo
    import lvi_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, n_wr;
    logic [PW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_count, n_count;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_count = r_count;

endmodule

FILE: hdl/lvi_front.sv
module lvi_front
    import lvi_pkg::*;
#(
    parameter int UNIFORM_BITS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  logic [UNIFORM_BITS-1:0] i_u,
    output t_front_stat             o_stat,
    output logic                    o_push,
    output t_norm                   o_entry
);

    localparam logic [UNIFORM_BITS-1:0] HALF = {1'b1, {(UNIFORM_BITS-1){1'b0}}};

    logic                    r_f1_valid, n_f1_valid;
    logic                    r_f2_valid;
    logic [UNIFORM_BITS-1:0] r_f1_w, n_f1_w;
    logic                    r_f1_up, n_f1_up;
    logic [UNIFORM_BITS-1:0] r_f2_w;
    logic                    r_f2_up;
    logic [K_W-1:0]          r_f2_e, n_f2_e;
    logic [UNIFORM_BITS:0]   w_diff;
    logic [UNIFORM_BITS+LOG_FRAC-1:0] w_shifted;

    // stage 1: fold the upper half onto 2^B - u, drop zero
    always_comb begin
        w_diff     = {1'b1, {UNIFORM_BITS{1'b0}}} - {1'b0, i_u};
        n_f1_up    = i_u > HALF;
        n_f1_w     = n_f1_up ? w_diff[UNIFORM_BITS-1:0] : i_u;
        n_f1_valid = i_accept && (i_u != '0);
    end

    // stage 2: find the top set bit
    always_comb begin
        n_f2_e = '0;
        for (int i = 0; i < UNIFORM_BITS; i++) begin
            if (r_f1_w[i]) begin
                n_f2_e = K_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
        end else begin
            r_f1_valid <= n_f1_valid;
            r_f2_valid <= r_f1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1_w  <= n_f1_w;
        r_f1_up <= n_f1_up;
        r_f2_w  <= r_f1_w;
        r_f2_up <= r_f1_up;
        r_f2_e  <= n_f2_e;
    end

    // normalize so the top set bit lands on bit LOG_FRAC
    assign w_shifted = {r_f2_w, {LOG_FRAC{1'b0}}} >> r_f2_e;

    assign o_push        = r_f2_valid;
    assign o_entry.upper = r_f2_up;
    assign o_entry.k     = K_W'(UNIFORM_BITS - 1) - r_f2_e;
    assign o_entry.mant  = w_shifted[MANT_W-1:0];

    assign o_stat.f1_valid = r_f1_valid;
    assign o_stat.f2_valid = r_f2_valid;

endmodule

FILE: hdl/lvi_back.sv
module lvi_back
    import lvi_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_norm   i_q_entry,
    output logic    o_q_pop,
    input  t_cfg    i_cfg,
    input  logic    i_out_room,
    output logic    o_res_push,
    output t_result o_res
);

    localparam int SH = LOG_FRAC - FRACTION_BITS;
    localparam logic [M_W-1:0] M_HALF = (SH == 0) ? '0 : (M_W'(1) << (SH - 1));
    localparam logic [63:0] LO_HALF = 64'd1 << (FRACTION_BITS - 1);
    localparam int HI_SHIFT = 32 - FRACTION_BITS;
    // stage 0, squaring steps, three log stages, four scale stages
    localparam int NST = 1 + LOG_FRAC + 7;
    localparam logic signed [65:0] V_MAX = 66'sd2147483647;
    localparam logic signed [65:0] V_MIN = -66'sd2147483648;

    logic             r_valid [NST];
    logic             w_adv;

    logic [MANT_W-1:0]   r_sq_mant [LOG_FRAC+1];
    logic [LOG_FRAC-1:0] r_sq_frac [LOG_FRAC+1];
    logic [K_W-1:0]      r_sq_k    [LOG_FRAC+1];
    logic                r_sq_up   [LOG_FRAC+1];
    logic [MANT_W-1:0]   n_sq_mant [1:LOG_FRAC];
    logic                n_sq_bit  [1:LOG_FRAC];
    logic [2*MANT_W-1:0] w_prod    [1:LOG_FRAC];

    logic [M_W-1:0]      r_l1_kln;
    logic [LOG_FRAC-1:0] r_l1_fln;
    logic                r_l1_up;
    logic [M_W-1:0]      r_l2_lm;
    logic                r_l2_up;
    logic [M_W-1:0]      r_l3_m;
    logic                r_l3_up;
    logic [34:0]         r_s1_hi;
    logic [62:0]         r_s1_lo;
    logic [M_W-1:0]      r_s1_m;
    logic                r_s1_up;
    logic [63:0]         r_s2_hi;
    logic [63:0]         r_s2_lo;
    logic [M_W-1:0]      r_s2_m;
    logic                r_s2_up;
    logic [63:0]         r_s3_mag;
    logic                r_s3_up;
    t_result             r_s4_res, n_s4_res;

    logic [2*LOG_FRAC-1:0] w_fprod;
    logic [63:0]           n_s3_mag;
    logic signed [65:0]    w_base, w_smag, w_v;

    // hold every stage while the last one cannot drain
    assign w_adv      = !(r_valid[NST-1] && !i_out_room);
    assign o_q_pop    = w_adv && i_q_valid;
    assign o_res_push = w_adv && r_valid[NST-1];
    assign o_res      = r_s4_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NST; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else if (w_adv) begin
            r_valid[0] <= i_q_valid;
            for (int i = 1; i < NST; i++) begin
                r_valid[i] <= r_valid[i-1];
            end
        end
    end

    // one truncated squaring per stage yields one bit of log2
    always_comb begin
        for (int s = 1; s <= LOG_FRAC; s++) begin
            w_prod[s]    = (2*MANT_W)'(r_sq_mant[s-1]) * (2*MANT_W)'(r_sq_mant[s-1]);
            n_sq_bit[s]  = w_prod[s][2*MANT_W-1];
            n_sq_mant[s] = n_sq_bit[s] ? w_prod[s][2*MANT_W-1:LOG_FRAC+1]
                                       : w_prod[s][2*MANT_W-2:LOG_FRAC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sq_mant[0] <= i_q_entry.mant;
            r_sq_frac[0] <= '0;
            r_sq_k[0]    <= i_q_entry.k;
            r_sq_up[0]   <= i_q_entry.upper;
            for (int s = 1; s <= LOG_FRAC; s++) begin
                r_sq_mant[s] <= n_sq_mant[s];
                r_sq_frac[s] <= {r_sq_frac[s-1][LOG_FRAC-2:0], n_sq_bit[s]};
                r_sq_k[s]    <= r_sq_k[s-1];
                r_sq_up[s]   <= r_sq_up[s-1];
            end
        end
    end

    assign w_fprod = (2*LOG_FRAC)'(r_sq_frac[LOG_FRAC]) * (2*LOG_FRAC)'(LN2_Q30);

    always_comb begin
        n_s3_mag = i_cfg.use_ls ? (r_s2_hi + r_s2_lo) : 64'(r_s2_m);
    end

    // apply sign and, when use_ls is set, location, then clip to 32 bits
    always_comb begin
        w_base = i_cfg.use_ls ? 66'(i_cfg.location) : '0;
        w_smag = $signed({2'b00, r_s3_mag});
        w_v    = r_s3_up ? (w_base + w_smag) : (w_base - w_smag);
        n_s4_res.saturated = 1'b0;
        n_s4_res.variate   = w_v[31:0];
        if (w_v > V_MAX) begin
            n_s4_res.saturated = 1'b1;
            n_s4_res.variate   = V_MAX[31:0];
        end else if (w_v < V_MIN) begin
            n_s4_res.saturated = 1'b1;
            n_s4_res.variate   = V_MIN[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_l1_kln <= M_W'(r_sq_k[LOG_FRAC]) * M_W'(LN2_Q30);
            r_l1_fln <= w_fprod[2*LOG_FRAC-1:LOG_FRAC];
            r_l1_up  <= r_sq_up[LOG_FRAC];

            r_l2_lm  <= r_l1_kln - M_W'(r_l1_fln);
            r_l2_up  <= r_l1_up;

            r_l3_m   <= (r_l2_lm + M_HALF) >> SH;
            r_l3_up  <= r_l2_up;

            r_s1_hi  <= 35'(i_cfg.scale) * 35'(r_l3_m[M_W-1:32]);
            r_s1_lo  <= 63'(i_cfg.scale) * 63'(r_l3_m[31:0]);
            r_s1_m   <= r_l3_m;
            r_s1_up  <= r_l3_up;

            r_s2_hi  <= 64'(r_s1_hi) << HI_SHIFT;
            r_s2_lo  <= (64'(r_s1_lo) + LO_HALF) >> FRACTION_BITS;
            r_s2_m   <= r_s1_m;
            r_s2_up  <= r_s1_up;

            r_s3_mag <= n_s3_mag;
            r_s3_up  <= r_s2_up;

            r_s4_res <= n_s4_res;
        end
    end

endmodule

FILE: hdl/laplace_variate_by_inversion.sv
// Laplace variate sampler by inversion of the CDF.
// Input queue side: a uniform fraction u is taken when push is high and full
// is low. A zero sample is dropped and gives no result. Result queue side:
// the oldest result sits on o_variate / o_saturated while empty is low and
// leaves at an edge with pop high.
// Configuration: a beat on valid/ready writes register i_cfg_index
// (0 mode, 1 location, 2 scale); ready is always high. Index 3 is ignored.
// Write configuration only while no sample is in flight.
// Throughput: one sample per cycle while full is low and the receiver keeps
// popping. A sample passes the front stages, the middle queue, the 30-stage
// squaring pipeline that produces log2 one bit per stage and the scale stages.
// Reset clears both queues and all pipeline valids and loads mode 0,
// location 0, scale 1.0.
// When the receiver stops popping, the two-entry result queue fills, the
// back pipeline holds, the four-entry middle queue fills and full rises.
module laplace_variate_by_inversion
    import lvi_pkg::*;
#(
    parameter int UNIFORM_BITS  = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [UNIFORM_BITS-1:0] i_uniform_fraction,
    output logic                    empty,
    input  logic                    pop,
    output logic signed [31:0]      o_variate,
    output logic                    o_saturated,
    input  logic                    valid,
    output logic                    ready,
    input  logic [1:0]              i_cfg_index,
    input  logic [31:0]             i_cfg_data
);

    localparam int QCW = $clog2(MID_DEPTH + 1);
    localparam int OCW = $clog2(OUT_DEPTH + 1);

    t_cfg          r_cfg, n_cfg;
    t_front_stat   w_stat;
    logic          w_accept;
    logic          w_f_push;
    t_norm         w_f_entry;
    t_norm         w_q_entry;
    logic [QCW-1:0] w_q_count;
    logic          w_q_pop;
    logic [QCW:0]  w_credit;
    logic          w_res_push;
    t_result       w_res_in, w_res_out;
    logic [OCW-1:0] w_out_count;
    logic          w_out_pop;

    assign ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (valid && ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_USE_LS:   n_cfg.use_ls   = i_cfg_data[0];
                CFG_LOCATION: n_cfg.location = i_cfg_data;
                CFG_SCALE:    n_cfg.scale    = i_cfg_data[30:0];
                default:      n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.use_ls   <= 1'b0;
            r_cfg.location <= '0;
            r_cfg.scale    <= SCALE_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // count items in the front stages against free queue slots
    assign w_credit = (QCW+1)'(w_q_count) + (QCW+1)'(w_stat.f1_valid)
                    + (QCW+1)'(w_stat.f2_valid);
    assign full     = w_credit >= (QCW+1)'(MID_DEPTH);
    assign w_accept = push && !full;

    lvi_front #(
        .UNIFORM_BITS(UNIFORM_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(w_accept),
        .i_u     (i_uniform_fraction),
        .o_stat  (w_stat),
        .o_push  (w_f_push),
        .o_entry (w_f_entry)
    );

    lvi_fifo #(
        .WIDTH($bits(t_norm)),
        .DEPTH(MID_DEPTH)
    ) u_mid_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_f_push),
        .i_data (w_f_entry),
        .i_pop  (w_q_pop),
        .o_data (w_q_entry),
        .o_count(w_q_count)
    );

    lvi_back #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_count != '0),
        .i_q_entry (w_q_entry),
        .o_q_pop   (w_q_pop),
        .i_cfg     (r_cfg),
        .i_out_room(w_out_count != OCW'(OUT_DEPTH)),
        .o_res_push(w_res_push),
        .o_res     (w_res_in)
    );

    assign w_out_pop = pop && !empty;

    lvi_fifo #(
        .WIDTH($bits(t_result)),
        .DEPTH(OUT_DEPTH)
    ) u_out_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_res_push),
        .i_data (w_res_in),
        .i_pop  (w_out_pop),
        .o_data (w_res_out),
        .o_count(w_out_count)
    );

    assign empty       = (w_out_count == '0);
    assign o_variate   = w_res_out.variate;
    assign o_saturated = w_res_out.saturated;

`ifndef SYNTH
    a_mid_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_credit <= (QCW+1)'(MID_DEPTH))
        else $error("middle queue credit exceeded");

    a_out_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_res_push && w_out_count == OCW'(OUT_DEPTH)))
        else $error("result pushed into full output queue");

    a_zero_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_uniform_fraction == '0) |=> !w_stat.f1_valid)
        else $error("zero sample entered the front");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");
`endif

endmodule
